/* hdl/gto_pkg.sv */
// Shared constants, types and helpers for the GGA time offset parser.
package gto_pkg;

  // Line position handling
  localparam logic [6:0] POS_LIMIT  = 7'd99;
  localparam logic [6:0] PREFIX_LEN = 7'd7;
  localparam logic [6:0] DIGIT_END  = 7'd13;
  localparam int unsigned DigitCount = 6;

  // Characters of interest
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // rtc mod 86400 = ((rtc >> 7) mod 675) << 7 | rtc[6:0]
  localparam int unsigned LowBits     = 7;
  localparam int unsigned QuotBits    = 32 - LowBits;
  localparam int unsigned RecipShift  = 25;
  localparam logic [15:0] RECIP_M     = 16'd49710;  // floor(2^25 / 675)
  localparam logic [10:0] MOD_BASE    = 11'd675;

  typedef logic [DigitCount-1:0][3:0] digit_vec_t;

  // Line end request handed from the line tracker to the offset pipeline
  typedef struct packed {
    logic       hit;
    digit_vec_t digits;
  } gto_cand_t;

  // Expected character of the "$GPGGA," prefix at a given position
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h24;  // $
      3'd1:    ch = 8'h47;  // G
      3'd2:    ch = 8'h50;  // P
      3'd3:    ch = 8'h47;  // G
      3'd4:    ch = 8'h47;  // G
      3'd5:    ch = 8'h41;  // A
      3'd6:    ch = 8'h2C;  // ,
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* hdl/gto_line_tracker.sv */
// Line tracker: position, prefix match and captured hhmmss digits.
module gto_line_tracker
  import gto_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] rx_byte,
  output gto_cand_t  cand
);

  logic [6:0] pos_r, pos_nxt;
  logic       prefix_ok_r, prefix_ok_nxt;
  digit_vec_t digits_r, digits_nxt;
  logic       is_eol;
  logic       hit;
  logic       is_digit;
  logic [3:0] digit_val;

  assign is_eol    = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
  assign hit       = (rx_byte == prefix_char(pos_r[2:0]));
  assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
  assign digit_val = is_digit ? 4'(rx_byte - CHAR_ZERO) : 4'd0;

  // Flag a matching line end; unreached digit slots are still zero
  assign cand.hit    = is_eol && prefix_ok_r && (pos_r >= PREFIX_LEN);
  assign cand.digits = digits_r;

  // Advance the line state for one byte
  always_comb begin
    pos_nxt       = pos_r;
    prefix_ok_nxt = prefix_ok_r;
    digits_nxt    = digits_r;
    if (is_eol) begin
      pos_nxt       = '0;
      prefix_ok_nxt = 1'b0;
      digits_nxt    = '0;
    end else begin
      if (pos_r < PREFIX_LEN) begin
        prefix_ok_nxt = (pos_r == 7'd0) ? hit : (prefix_ok_r && hit);
      end
      for (int k = 0; k < DigitCount; k++) begin
        if (pos_r == PREFIX_LEN + 7'(k)) begin
          digits_nxt[k] = digit_val;
        end
      end
      if (pos_r < POS_LIMIT) begin
        pos_nxt = pos_r + 7'd1;
      end
    end
  end

  // Update on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      prefix_ok_r <= 1'b0;
      digits_r    <= '0;
    end else if (acc) begin
      pos_r       <= pos_nxt;
      prefix_ok_r <= prefix_ok_nxt;
      digits_r    <= digits_nxt;
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LIMIT)
    else $error("line position beyond limit");

  a_prefix_pos: assert property (@(posedge clk) disable iff (!rst_n)
    prefix_ok_r |-> (pos_r != 7'd0))
    else $error("prefix flag set at line start");

  a_digits_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (digits_r != '0) |-> (pos_r > PREFIX_LEN))
    else $error("digits captured before time field");
`endif

endmodule

/* hdl/gga_time_offset_parser_top.sv */
// Top level: GGA time offset parser with line tracker and offset pipeline.
//
// Channel | Ports                                  | Direction
// --------+----------------------------------------+----------
// in      | in_valid, in_stall, in_rx_byte,        | request in
//         | in_rtc_count                           |
// out     | out_valid, out_stall, out_new_offset,  | request out
//         | out_gps_seconds                        |
//
// One byte is accepted per cycle while the pipeline can move.
// A matching line end passes the capture, time/reciprocal multiply, remainder and
// offset registers; if its offset changed, the compare loads the output register.
// Reset (rst_n low, synchronous) clears line state, stored offset and all
// valid flags. A stalled output holds; bytes keep flowing until the
// offset pipeline fills behind it, then in_stall rises.
module gga_time_offset_parser_top
  import gto_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic [31:0]        in_rtc_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] out_new_offset,
  output logic [18:0]        out_gps_seconds
);

  gto_cand_t cand;
  logic      in_acc;

  // Stage valid flags and ready chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;
  logic s4_go, out_load, out_free, differs;

  // Stage payloads
  digit_vec_t          digits1_r;
  logic [QuotBits-1:0] q1_r, q2_r;
  logic [LowBits-1:0]  lo1_r, lo2_r, lo3_r;
  logic [18:0]         tod2_r, tod3_r, tod4_r;
  logic [15:0]         est2_r;
  logic [10:0]         rem3_r;
  logic signed [19:0]  fresh4_r;

  // Output and stored offset
  logic               out_valid_r;
  logic signed [19:0] out_new_offset_r;
  logic [18:0]        out_gps_seconds_r;
  logic signed [19:0] stored_offset_r;

  // Combinational stage results
  logic [6:0]  hh, mm, ss;
  logic [18:0] tod_nxt;
  logic [40:0] recip_prod;
  logic [25:0] est_prod;
  logic [25:0] rem_diff;
  logic [9:0]  rem_fix;
  logic [16:0] day_sec;
  logic [19:0] fresh_nxt;

  gto_line_tracker u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .rx_byte (in_rx_byte),
    .cand    (cand)
  );

  // Ready chain from the output back to the input
  assign out_free = !out_valid_r || !out_stall;
  assign differs  = (fresh4_r != stored_offset_r);
  assign out_load = v4_r && differs && out_free;
  assign s4_go    = v4_r && (out_free || !differs);
  assign s4_rdy   = !v4_r || s4_go;
  assign s3_rdy   = !v3_r || s4_rdy;
  assign s2_rdy   = !v2_r || s3_rdy;
  assign s1_rdy   = !v1_r || s2_rdy;
  assign in_stall = !s1_rdy;
  assign in_acc   = in_valid && s1_rdy;

  // Time of day and quotient estimate of (rtc >> 7) / 675
  assign hh         = 7'(digits1_r[0]) * 7'd10 + 7'(digits1_r[1]);
  assign mm         = 7'(digits1_r[2]) * 7'd10 + 7'(digits1_r[3]);
  assign ss         = 7'(digits1_r[4]) * 7'd10 + 7'(digits1_r[5]);
  assign tod_nxt    = 19'(hh) * 19'd3600 + 19'(mm) * 19'd60 + 19'(ss);
  assign recip_prod = 41'(q1_r) * 41'(RECIP_M);

  // Remainder, within one base of the true value
  assign est_prod = 26'(est2_r) * 26'(MOD_BASE);
  assign rem_diff = 26'(q2_r) - est_prod;

  // Correct the remainder and form the offset
  assign rem_fix   = (rem3_r >= MOD_BASE) ? 10'(rem3_r - MOD_BASE) : rem3_r[9:0];
  assign day_sec   = {rem_fix, lo3_r};
  assign fresh_nxt = 20'(tod3_r) - 20'(day_sec) + 20'd1;

  // Advance the stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (s1_rdy) v1_r <= in_acc && cand.hit;
      if (s2_rdy) v2_r <= v1_r;
      if (s3_rdy) v3_r <= v2_r;
      if (s4_rdy) v4_r <= v3_r;
    end
  end

  // Move payloads along with their valid flags
  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      digits1_r <= cand.digits;
      q1_r      <= in_rtc_count[31:LowBits];
      lo1_r     <= in_rtc_count[LowBits-1:0];
    end
    if (s2_rdy) begin
      tod2_r <= tod_nxt;
      est2_r <= recip_prod[RecipShift +: 16];
      q2_r   <= q1_r;
      lo2_r  <= lo1_r;
    end
    if (s3_rdy) begin
      tod3_r <= tod2_r;
      rem3_r <= rem_diff[10:0];
      lo3_r  <= lo2_r;
    end
    if (s4_rdy) begin
      tod4_r   <= tod3_r;
      fresh4_r <= signed'(fresh_nxt);
    end
  end

  // Hold the result until taken; store a changed offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      stored_offset_r <= '0;
    end else begin
      if (out_free) out_valid_r <= out_load;
      if (out_load) stored_offset_r <= fresh4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_new_offset_r  <= fresh4_r;
      out_gps_seconds_r <= tod4_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_offset  = out_new_offset_r;
  assign out_gps_seconds = out_gps_seconds_r;

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (rem3_r < 11'd1350))
    else $error("quotient estimate off by more than one");

  a_stored_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(stored_offset_r)) |-> $past(out_load))
    else $error("stored offset changed without a result");

  a_out_matches_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_new_offset_r == stored_offset_r))
    else $error("result differs from stored offset");
`endif

endmodule

/* sim/tb_gga_time_offset_parser_top.sv */
// Testbench for the GGA time offset parser: byte stream stimulus with a line-level scoreboard.
`timescale 1ns / 100ps

module tb_gga_time_offset_parser_top;
  import gto_pkg::*;

  localparam int    CycleLimit = 600000;
  localparam string GGA_HEAD   = "$GPGGA,";

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte   = '0;
  logic [31:0]        in_rtc_count = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic signed [19:0] out_new_offset;
  logic [18:0]        out_gps_seconds;

  int  cycle_count = 0;
  int  bytes_sent  = 0;
  int  stall_left  = 0;
  bit  in_calm     = 1'b0;
  bit  out_calm    = 1'b0;

  // Predict offset updates from the byte stream and hold them until they come out
  class offset_scoreboard;
    typedef struct {
      logic signed [19:0] new_offset;
      logic [18:0]        gps_seconds;
    } offset_update_t;

    logic [6:0]         line_pos;
    bit                 head_ok;
    logic [3:0]         digit_q [DigitCount];
    logic signed [19:0] last_offset;
    offset_update_t     update_q [$];
    int                 errors;

    function new();
      clear_line();
      last_offset = '0;
      errors      = 0;
    endfunction

    function void clear_line();
      line_pos = '0;
      head_ok  = 1'b0;
      foreach (digit_q[i]) digit_q[i] = '0;
    endfunction

    function int pair(int first);
      return int'(digit_q[first]) * 10 + int'(digit_q[first + 1]);
    endfunction

    // Advance the line state by one accepted byte
    function void note_byte(logic [7:0] rx, logic [31:0] rtc);
      int unsigned    tod;
      int             fresh;
      bit             hit;
      offset_update_t upd;
      if (rx == CHAR_LF || rx == CHAR_CR) begin
        if (head_ok && line_pos >= PREFIX_LEN) begin
          tod   = pair(0) * 3600 + pair(2) * 60 + pair(4);
          fresh = int'(tod) - int'(rtc % 32'd86400) + 1;
          if (fresh[19:0] != last_offset) begin
            last_offset     = fresh[19:0];
            upd.new_offset  = fresh[19:0];
            upd.gps_seconds = tod[18:0];
            update_q.push_back(upd);
          end
        end
        clear_line();
      end else begin
        if (line_pos < PREFIX_LEN) begin
          hit     = (rx == GGA_HEAD[line_pos]);
          head_ok = (line_pos == 0) ? hit : (head_ok && hit);
        end else if (line_pos < DIGIT_END) begin
          // non-digit characters count as zero
          digit_q[line_pos - PREFIX_LEN] =
            (rx >= CHAR_ZERO && rx <= CHAR_NINE) ? 4'(rx - CHAR_ZERO) : 4'd0;
        end
        if (line_pos < POS_LIMIT) line_pos++;
      end
    endfunction

    // Compare one accepted result with the oldest update
    function void check_result(logic signed [19:0] offset, logic [18:0] gps);
      offset_update_t upd;
      if (update_q.size() == 0) begin
        $error("unexpected result: new_offset %0d gps_seconds %0d", offset, gps);
        errors++;
        return;
      end
      upd = update_q.pop_front();
      if (offset !== upd.new_offset) begin
        $error("new_offset: expected %0d, got %0d", upd.new_offset, offset);
        errors++;
      end
      if (gps !== upd.gps_seconds) begin
        $error("gps_seconds: expected %0d, got %0d", upd.gps_seconds, gps);
        errors++;
      end
    endfunction
  endclass

  offset_scoreboard sb = new();

  gga_time_offset_parser_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .in_rtc_count    (in_rtc_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_new_offset  (out_new_offset),
    .out_gps_seconds (out_gps_seconds)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // Any byte except a line end
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Check results and stall the result channel at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_new_offset, out_gps_seconds);
    if (stall_left != 0) stall_left = stall_left - 1;
    else if (!out_calm && $urandom_range(0, 99) < 30) stall_left = idle_len();
    if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
    out_stall <= (stall_left != 0);
  end

  // Present one request, with an optional gap in front, and wait until it is taken
  task automatic send_byte(input logic [7:0] rx, input logic [31:0] rtc);
    int gap;
    gap = (in_calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_rx_byte   <= rx;
    in_rtc_count <= rtc;
    do @(posedge clk); while (in_stall);
    sb.note_byte(rx, rtc);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic [7:0] term, input logic [31:0] rtc);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], $urandom());
    send_byte(term, rtc);
  endtask

  // Hold the sender until every predicted update has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.update_q.size() != 0);
  endtask

  initial begin : stimulus
    logic [7:0]  line_q [$];
    logic [7:0]  tod_chars [DigitCount];
    logic [7:0]  prev_chars [DigitCount];
    logic [31:0] line_rtc;
    logic [31:0] prev_rtc;
    int          kind;
    int          cut;
    int          tail_len;
    bit          all_nines;
    bit          mid_done;

    foreach (prev_chars[i]) prev_chars[i] = CHAR_ZERO;
    prev_rtc = '0;
    mid_done = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: truncated time, empty line, non-digit with smallest offset,
    // short line, byte extremes
    send_text("$GPGGA,9", CHAR_CR, 32'd0);
    send_byte(CHAR_LF, 32'hFFFF_FFFF);
    send_text("$GPGGA,0a0000", CHAR_CR, 32'd86399);
    send_text("$GPG", CHAR_LF, 32'd0);
    send_byte(8'h00, 32'd0);
    send_byte(8'hFF, 32'hFFFF_FFFF);
    send_byte(CHAR_CR, 32'hFFFF_FFFF);
    drain();

    // Random lines: mostly well-formed sentences, some broken, some noise
    while (bytes_sent < 1300) begin
      if (!mid_done && bytes_sent >= 650) begin
        drain();
        mid_done = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) in_calm = !in_calm;
      kind = $urandom_range(0, 99);
      line_q.delete();

      // Repeat the previous time and counter so the offset stays unchanged
      if (kind >= 60 && kind < 70) begin
        tod_chars = prev_chars;
        line_rtc  = prev_rtc;
      end else begin
        all_nines = ($urandom_range(0, 19) == 0);
        foreach (tod_chars[i]) begin
          if (all_nines) tod_chars[i] = CHAR_NINE;
          else if ($urandom_range(0, 99) < 85) tod_chars[i] = CHAR_ZERO + 8'($urandom_range(0, 9));
          else tod_chars[i] = text_byte();
        end
        case ($urandom_range(0, 19))
          0:       line_rtc = 32'd0;
          1:       line_rtc = 32'hFFFF_FFFF;
          2:       line_rtc = 32'd86399;
          3:       line_rtc = 32'd86400 * $urandom_range(0, 49000);
          default: line_rtc = $urandom();
        endcase
      end

      if (kind < 92) begin
        for (int i = 0; i < GGA_HEAD.len(); i++) line_q.push_back(GGA_HEAD[i]);
        foreach (tod_chars[i]) line_q.push_back(tod_chars[i]);
        tail_len = (kind >= 70 && kind < 76) ? $urandom_range(90, 120) : $urandom_range(0, 15);
        repeat (tail_len) line_q.push_back(text_byte());
        // cut the line short before or inside the time field
        if (kind >= 76 && kind < 84) begin
          cut = $urandom_range(0, 12);
          while (line_q.size() > cut) void'(line_q.pop_back());
        end
        // corrupt one prefix character
        if (kind >= 84) line_q[$urandom_range(0, 6)] = text_byte();
      end else begin
        repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
      end

      foreach (line_q[i]) send_byte(line_q[i], $urandom());
      send_byte(($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF, line_rtc);
      if ($urandom_range(0, 2) == 0) send_byte(CHAR_LF, $urandom());
      prev_chars = tod_chars;
      prev_rtc   = line_rtc;
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.update_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/gto_pkg.sv
hdl/gto_line_tracker.sv
hdl/gga_time_offset_parser_top.sv
sim/tb_gga_time_offset_parser_top.sv
